>>> rtl/smat_pkg.sv
// Shared types and constants for the small matrix add, multiply and transpose unit.
package smat_pkg;

    localparam int          DATA_W     = 32;
    localparam int          IDX_W      = 3;
    localparam int          SIZE_W     = 4;
    localparam int          PADDR_W    = 3;
    localparam int          PDATA_W    = 32;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;
    localparam logic        CFG_SIZE   = 1'b0;

    typedef enum logic [2:0] {
        F_LOAD_A  = 3'd0,
        F_LOAD_B  = 3'd1,
        F_ADD     = 3'd2,
        F_MUL     = 3'd3,
        F_TRANS_A = 3'd4,
        F_TRANS_B = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_ISSUE = 2'd1,
        S_WAIT  = 2'd2
    } t_seq_state;

    typedef struct packed {
        logic  valid;
        logic  first;
        logic  lastk;
        t_func op;
    } t_iss;

    typedef struct packed {
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
    } t_pos;

endpackage

>>> rtl/smat_mem.sv
// Single-port-write, single-port-read matrix store with registered read data.
module smat_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [AW-1:0]                 i_waddr,
    input  logic [smat_pkg::DATA_W-1:0]   i_wdata,
    input  logic [AW-1:0]                 i_raddr,
    output logic [smat_pkg::DATA_W-1:0]   o_rdata
);

    logic [smat_pkg::DATA_W-1:0] r_mem [DEPTH];
    logic [smat_pkg::DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/smat_seq.sv
// Sequencer: accepts items, writes loads, walks result elements and issues memory reads.
module smat_seq #(
    parameter int MAX_DIM = 8,
    parameter int IW      = 3,
    parameter int AW      = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic [2:0]                    i_func,
    input  logic [smat_pkg::IDX_W-1:0]    i_row,
    input  logic [smat_pkg::IDX_W-1:0]    i_col,
    input  logic [smat_pkg::SIZE_W-1:0]   i_size,
    input  logic                          i_busy,
    output logic                          o_in_stall,
    output logic                          o_we_a,
    output logic                          o_we_b,
    output logic [AW-1:0]                 o_waddr,
    output logic [AW-1:0]                 o_raddr_a,
    output logic [AW-1:0]                 o_raddr_b,
    output smat_pkg::t_iss                o_iss,
    output smat_pkg::t_pos                o_pos
);

    smat_pkg::t_seq_state r_state, n_state;
    smat_pkg::t_func      r_op;
    logic [IW-1:0]        r_row, r_col, r_k, r_lim;

    smat_pkg::t_func      w_func;
    logic                 w_accept;
    logic                 w_is_op;
    logic                 w_in_range;
    logic [4:0]           w_dim;
    logic [IW-1:0]        w_lim;
    logic                 w_k_end;
    logic                 w_elem_end;

    function automatic logic [AW-1:0] f_cell(input logic [31:0] x, input logic [31:0] y);
        return AW'(x * MAX_DIM + y);
    endfunction

    assign w_func     = smat_pkg::t_func'(i_func);
    assign w_accept   = i_in_valid && (r_state == smat_pkg::S_IDLE);
    assign w_is_op    = (w_func == smat_pkg::F_ADD) || (w_func == smat_pkg::F_MUL) ||
                        (w_func == smat_pkg::F_TRANS_A) || (w_func == smat_pkg::F_TRANS_B);
    assign w_in_range = (32'(i_row) < MAX_DIM) && (32'(i_col) < MAX_DIM);
    assign w_k_end    = (r_op != smat_pkg::F_MUL) || (r_k == r_lim);
    assign w_elem_end = (r_row == r_lim) && (r_col == r_lim);
    assign w_lim      = IW'(w_dim - 5'd1);

    always_comb begin
        if (i_size == '0) begin
            w_dim = 5'd1;
        end else if ({1'b0, i_size} > 5'(MAX_DIM)) begin
            w_dim = 5'(MAX_DIM);
        end else begin
            w_dim = {1'b0, i_size};
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            smat_pkg::S_IDLE: begin
                if (w_accept && w_is_op) begin
                    n_state = smat_pkg::S_ISSUE;
                end
            end
            smat_pkg::S_ISSUE: begin
                if (w_k_end) begin
                    n_state = smat_pkg::S_WAIT;
                end
            end
            smat_pkg::S_WAIT: begin
                if (!i_busy) begin
                    n_state = w_elem_end ? smat_pkg::S_IDLE : smat_pkg::S_ISSUE;
                end
            end
            default: n_state = smat_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall = (r_state != smat_pkg::S_IDLE);
        o_we_a     = w_accept && (w_func == smat_pkg::F_LOAD_A) && w_in_range;
        o_we_b     = w_accept && (w_func == smat_pkg::F_LOAD_B) && w_in_range;
        o_waddr    = f_cell(32'(i_row), 32'(i_col));
        o_iss.valid = (r_state == smat_pkg::S_ISSUE);
        o_iss.first = (r_k == '0);
        o_iss.lastk = w_k_end;
        o_iss.op    = r_op;
        unique case (r_op)
            smat_pkg::F_MUL: begin
                o_raddr_a = f_cell(32'(r_row), 32'(r_k));
                o_raddr_b = f_cell(32'(r_k), 32'(r_col));
            end
            smat_pkg::F_TRANS_A, smat_pkg::F_TRANS_B: begin
                o_raddr_a = f_cell(32'(r_col), 32'(r_row));
                o_raddr_b = f_cell(32'(r_col), 32'(r_row));
            end
            default: begin
                o_raddr_a = f_cell(32'(r_row), 32'(r_col));
                o_raddr_b = f_cell(32'(r_row), 32'(r_col));
            end
        endcase
        o_pos.row  = smat_pkg::IDX_W'(r_row);
        o_pos.col  = smat_pkg::IDX_W'(r_col);
        o_pos.last = w_elem_end;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= smat_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == smat_pkg::S_IDLE && w_accept && w_is_op) begin
            r_op  <= w_func;
            r_row <= '0;
            r_col <= '0;
            r_k   <= '0;
            r_lim <= w_lim;
        end else if (r_state == smat_pkg::S_ISSUE && !w_k_end) begin
            r_k <= r_k + IW'(1);
        end else if (r_state == smat_pkg::S_WAIT && !i_busy && !w_elem_end) begin
            r_k <= '0;
            if (r_col == r_lim) begin
                r_col <= '0;
                r_row <= r_row + IW'(1);
            end else begin
                r_col <= r_col + IW'(1);
            end
        end
    end

endmodule

>>> rtl/smat_dp.sv
// Datapath: combines read data, accumulates terms and holds the output register.
module smat_dp (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  smat_pkg::t_iss                     i_iss,
    input  smat_pkg::t_pos                     i_pos,
    input  logic [smat_pkg::DATA_W-1:0]        i_rd_a,
    input  logic [smat_pkg::DATA_W-1:0]        i_rd_b,
    input  logic                               i_out_stall,
    output logic                               o_busy,
    output logic                               o_out_valid,
    output logic [smat_pkg::IDX_W-1:0]         o_out_row,
    output logic [smat_pkg::IDX_W-1:0]         o_out_col,
    output logic signed [smat_pkg::DATA_W-1:0] o_result,
    output logic                               o_last
);

    smat_pkg::t_iss               r_tag;
    logic                         r_t_valid, r_t_first, r_t_last;
    logic [smat_pkg::DATA_W-1:0]  r_term;
    logic [smat_pkg::DATA_W-1:0]  r_acc;
    logic                         r_acc_full;
    logic                         r_out_valid;
    logic [smat_pkg::IDX_W-1:0]   r_out_row, r_out_col;
    logic [smat_pkg::DATA_W-1:0]  r_out_result;
    logic                         r_out_last;

    logic [smat_pkg::DATA_W-1:0]  w_term;
    logic                         w_out_load;

    always_comb begin
        unique case (r_tag.op)
            smat_pkg::F_ADD:     w_term = i_rd_a + i_rd_b;
            smat_pkg::F_MUL:     w_term = i_rd_a * i_rd_b;
            smat_pkg::F_TRANS_A: w_term = i_rd_a;
            default:             w_term = i_rd_b;
        endcase
    end

    assign w_out_load = r_acc_full && (!r_out_valid || !i_out_stall);
    assign o_busy     = r_tag.valid || r_t_valid || r_acc_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= '0;
            r_t_valid   <= 1'b0;
            r_acc_full  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_tag     <= i_iss;
            r_t_valid <= r_tag.valid;
            if (r_t_valid && r_t_last) begin
                r_acc_full <= 1'b1;
            end else if (w_out_load) begin
                r_acc_full <= 1'b0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_t_first <= r_tag.first;
        r_t_last  <= r_tag.lastk;
        r_term    <= w_term;
        if (r_t_valid) begin
            r_acc <= r_t_first ? r_term : r_acc + r_term;
        end
        if (w_out_load) begin
            r_out_row    <= i_pos.row;
            r_out_col    <= i_pos.col;
            r_out_result <= r_acc;
            r_out_last   <= i_pos.last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_result    = r_out_result;
    assign o_last      = r_out_last;

endmodule

>>> rtl/small_matrix_add_mul_transpose_top.sv
// Top level of the small matrix add, multiply and transpose unit.
// Matrices A and B live in two memories of MAX_DIM*MAX_DIM words with registered reads.
// An operation of active size n streams n*n results in row-major order, last set on
// the final one; each result element issues its reads, runs them through one shared
// multiply-add path and waits for it to drain. A multiply does one memory read and one
// multiply-accumulate per k, and an element also waits while the output is stalled.
// The input stalls until the last element enters the output register; the next item
// is taken while that result still waits.
module small_matrix_add_mul_transpose_top #(
    parameter int MAX_DIM = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [2:0]                          i_func,
    input  logic [smat_pkg::IDX_W-1:0]          i_row,
    input  logic [smat_pkg::IDX_W-1:0]          i_col,
    input  logic signed [smat_pkg::DATA_W-1:0]  i_value,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [smat_pkg::IDX_W-1:0]          o_out_row,
    output logic [smat_pkg::IDX_W-1:0]          o_out_col,
    output logic signed [smat_pkg::DATA_W-1:0]  o_result,
    output logic                                o_last,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [smat_pkg::PADDR_W-1:0]        paddr,
    input  logic [smat_pkg::PDATA_W-1:0]        pwdata,
    output logic [smat_pkg::PDATA_W-1:0]        prdata,
    output logic                                pready
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;

    logic [smat_pkg::SIZE_W-1:0]  r_size;
    logic                         w_cfg_wr;
    logic                         w_we_a, w_we_b, w_busy;
    logic [AW-1:0]                w_waddr, w_raddr_a, w_raddr_b;
    logic [smat_pkg::DATA_W-1:0]  w_rd_a, w_rd_b;
    smat_pkg::t_iss               w_iss;
    smat_pkg::t_pos               w_pos;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign prdata   = (paddr[2] == smat_pkg::CFG_SIZE) ?
                      {{(smat_pkg::PDATA_W - smat_pkg::SIZE_W){1'b0}}, r_size} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= smat_pkg::SIZE_RESET;
        end else if (w_cfg_wr && paddr[2] == smat_pkg::CFG_SIZE) begin
            r_size <= pwdata[smat_pkg::SIZE_W-1:0];
        end
    end

    smat_seq #(
        .MAX_DIM (MAX_DIM),
        .IW      (IW),
        .AW      (AW)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_size     (r_size),
        .i_busy     (w_busy),
        .o_in_stall (o_in_stall),
        .o_we_a     (w_we_a),
        .o_we_b     (w_we_b),
        .o_waddr    (w_waddr),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .o_iss      (w_iss),
        .o_pos      (w_pos)
    );

    smat_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_a),
        .o_rdata (w_rd_a)
    );

    smat_mem #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_mem_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (w_waddr),
        .i_wdata (i_value),
        .i_raddr (w_raddr_b),
        .o_rdata (w_rd_b)
    );

    smat_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_iss       (w_iss),
        .i_pos       (w_pos),
        .i_rd_a      (w_rd_a),
        .i_rd_b      (w_rd_b),
        .i_out_stall (i_out_stall),
        .o_busy      (w_busy),
        .o_out_valid (o_out_valid),
        .o_out_row   (o_out_row),
        .o_out_col   (o_out_col),
        .o_result    (o_result),
        .o_last      (o_last)
    );

endmodule

>>> rtl/smat_chk.sv
// Port-level checker for the small matrix unit and its bind to the top level.
module smat_chk (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_in_valid,
    input logic                                o_in_stall,
    input logic [2:0]                          i_func,
    input logic                                o_out_valid,
    input logic                                i_out_stall,
    input logic [smat_pkg::IDX_W-1:0]          o_out_row,
    input logic [smat_pkg::IDX_W-1:0]          o_out_col,
    input logic signed [smat_pkg::DATA_W-1:0]  o_result,
    input logic                                o_last
);

    logic w_in_xfer;
    logic w_is_op;
    logic w_is_load;

    assign w_in_xfer = i_in_valid && !o_in_stall;
    assign w_is_op   = (i_func == 3'(smat_pkg::F_ADD)) || (i_func == 3'(smat_pkg::F_MUL)) ||
                       (i_func == 3'(smat_pkg::F_TRANS_A)) ||
                       (i_func == 3'(smat_pkg::F_TRANS_B));
    assign w_is_load = (i_func == 3'(smat_pkg::F_LOAD_A)) || (i_func == 3'(smat_pkg::F_LOAD_B));

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_result) &&
        $stable(o_out_row) && $stable(o_out_col) && $stable(o_last))
        else $error("stalled result transfer changed");

    a_op_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_is_op |=> o_in_stall)
        else $error("operation transfer did not block input");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer && w_is_load |=> !o_in_stall)
        else $error("load transfer blocked input");

    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_last |-> o_out_row == o_out_col)
        else $error("last result off the diagonal");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("reset left block active");

endmodule

bind small_matrix_add_mul_transpose_top smat_chk u_chk (.*);
